@@ design/http_response_header_parser_unit_macros.svh @@
// ----------------------------------------------------------------------------
// HTTP response header parser assertion macros
// Shared concurrent assertion forms, clocked on clk with reset arst_n.
// ----------------------------------------------------------------------------
`ifndef HTTP_RESPONSE_HEADER_PARSER_UNIT_MACROS_SVH
`define HTTP_RESPONSE_HEADER_PARSER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HRHP_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define HRHP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

@@ design/hrhp_pkg.sv @@
// ----------------------------------------------------------------------------
// HTTP response header parser package
// Beat types, parser state codes, character constants and byte classes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hrhp_pkg;

	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  verdict;
		logic [1:0]  text_kind;
		logic [7:0]  text_byte;
		logic        name_begin;
		logic        header_end;
		logic [7:0]  version_major;
		logic [7:0]  version_minor;
		logic [15:0] resp_code;
	} out_beat_t;

	typedef struct packed {
		logic [4:0]  parse_state;
		logic [7:0]  major_value;
		logic [7:0]  minor_value;
		logic [15:0] code_value;
		logic        seen_header;
	} parse_ctx_t;

	localparam logic REQ_BYTE    = 1'b0;
	localparam logic REQ_RESTART = 1'b1;

	localparam logic [1:0] VERDICT_MORE   = 2'd0;
	localparam logic [1:0] VERDICT_DONE   = 2'd1;
	localparam logic [1:0] VERDICT_REJECT = 2'd2;

	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_STATUS = 2'd1;
	localparam logic [1:0] KIND_NAME   = 2'd2;
	localparam logic [1:0] KIND_VALUE  = 2'd3;

	localparam logic [4:0] S_H     = 5'd0;
	localparam logic [4:0] S_T1    = 5'd1;
	localparam logic [4:0] S_T2    = 5'd2;
	localparam logic [4:0] S_P     = 5'd3;
	localparam logic [4:0] S_SLASH = 5'd4;
	localparam logic [4:0] S_MAJ0  = 5'd5;
	localparam logic [4:0] S_MAJ   = 5'd6;
	localparam logic [4:0] S_MIN0  = 5'd7;
	localparam logic [4:0] S_MIN   = 5'd8;
	localparam logic [4:0] S_CODE0 = 5'd9;
	localparam logic [4:0] S_CODE  = 5'd10;
	localparam logic [4:0] S_STEXT = 5'd11;
	localparam logic [4:0] S_NL1   = 5'd12;
	localparam logic [4:0] S_LINE  = 5'd13;
	localparam logic [4:0] S_LWS   = 5'd14;
	localparam logic [4:0] S_NAME  = 5'd15;
	localparam logic [4:0] S_SPACE = 5'd16;
	localparam logic [4:0] S_VALUE = 5'd17;
	localparam logic [4:0] S_NL2   = 5'd18;
	localparam logic [4:0] S_NL3   = 5'd19;
	localparam logic [4:0] S_DONE  = 5'd20;

	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CTL_MAX  = 8'd31;
	localparam logic [7:0] CH_DEL   = 8'd127;

	function automatic logic is_ctl(input logic [7:0] c);
		return (c <= CTL_MAX) || (c == CH_DEL);
	endfunction

	function automatic logic is_dec_char(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_separator(input logic [7:0] c);
		logic sep;
		case (c)
			8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40,
			8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
			8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D,
			8'h7B, 8'h7D, 8'h20, 8'h09: begin
				sep = 1'b1;
			end
			default: begin
				sep = 1'b0;
			end
		endcase
		return sep;
	endfunction

	function automatic logic is_token(input logic [7:0] c);
		return (c <= CH_DEL) && !is_ctl(c) && !is_separator(c);
	endfunction

endpackage

@@ design/hrhp_step.sv @@
// ----------------------------------------------------------------------------
// HTTP response header parser step logic
// Next parser context and result beat for one byte or restart request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hrhp_step (
	input  hrhp_pkg::in_beat_t   beat,
	input  hrhp_pkg::parse_ctx_t cur,
	output hrhp_pkg::parse_ctx_t nxt,
	output hrhp_pkg::out_beat_t  result
);
	import hrhp_pkg::*;

	logic [7:0]  c;
	logic [11:0] maj_sum;
	logic [11:0] min_sum;
	logic [19:0] code_sum;
	logic [7:0]  maj_acc;
	logic [7:0]  min_acc;
	logic [15:0] code_acc;
	logic        ok;
	logic [1:0]  verdict;
	logic [1:0]  kind;
	logic        nbeg;
	logic        hend;
	parse_ctx_t  n;

	assign c = beat.data_byte;

	assign maj_sum  = ({4'd0, cur.major_value} << 3) + ({4'd0, cur.major_value} << 1)
		+ {8'd0, c[3:0]};
	assign min_sum  = ({4'd0, cur.minor_value} << 3) + ({4'd0, cur.minor_value} << 1)
		+ {8'd0, c[3:0]};
	assign code_sum = ({4'd0, cur.code_value} << 3) + ({4'd0, cur.code_value} << 1)
		+ {16'd0, c[3:0]};

	assign maj_acc  = (maj_sum > 12'd255) ? 8'hFF : maj_sum[7:0];
	assign min_acc  = (min_sum > 12'd255) ? 8'hFF : min_sum[7:0];
	assign code_acc = (code_sum > 20'd65535) ? 16'hFFFF : code_sum[15:0];

	always_comb begin
		n       = cur;
		ok      = 1'b1;
		verdict = VERDICT_MORE;
		kind    = KIND_NONE;
		nbeg    = 1'b0;
		hend    = 1'b0;
		if (beat.req_type == REQ_RESTART) begin
			n.parse_state = S_H;
		end else begin
			case (cur.parse_state)
				S_H: begin
					if (c == CH_H) n.parse_state = S_T1;
					else ok = 1'b0;
				end
				S_T1: begin
					if (c == CH_T) n.parse_state = S_T2;
					else ok = 1'b0;
				end
				S_T2: begin
					if (c == CH_T) n.parse_state = S_P;
					else ok = 1'b0;
				end
				S_P: begin
					if (c == CH_P) n.parse_state = S_SLASH;
					else ok = 1'b0;
				end
				S_SLASH: begin
					if (c == CH_SLASH) begin
						n.major_value = 8'd0;
						n.minor_value = 8'd0;
						n.code_value  = 16'd0;
						n.parse_state = S_MAJ0;
					end else begin
						ok = 1'b0;
					end
				end
				S_MAJ0: begin
					if (is_dec_char(c)) begin
						n.major_value = maj_acc;
						n.parse_state = S_MAJ;
					end else begin
						ok = 1'b0;
					end
				end
				S_MAJ: begin
					if (c == CH_DOT) n.parse_state = S_MIN0;
					else if (is_dec_char(c)) n.major_value = maj_acc;
					else ok = 1'b0;
				end
				S_MIN0: begin
					if (is_dec_char(c)) begin
						n.minor_value = min_acc;
						n.parse_state = S_MIN;
					end else begin
						ok = 1'b0;
					end
				end
				S_MIN: begin
					if (c == CH_SP) n.parse_state = S_CODE0;
					else if (is_dec_char(c)) n.minor_value = min_acc;
					else ok = 1'b0;
				end
				S_CODE0: begin
					if (c >= CH_ONE && c <= CH_NINE) begin
						n.code_value  = code_acc;
						n.parse_state = S_CODE;
					end else begin
						ok = 1'b0;
					end
				end
				S_CODE: begin
					if (c == CH_SP) n.parse_state = S_STEXT;
					else if (is_dec_char(c)) n.code_value = code_acc;
					else ok = 1'b0;
				end
				S_STEXT: begin
					if (c == CH_CR) n.parse_state = S_NL1;
					else if (is_ctl(c)) ok = 1'b0;
					else kind = KIND_STATUS;
				end
				S_NL1: begin
					if (c == CH_LF) n.parse_state = S_LINE;
					else ok = 1'b0;
				end
				S_LINE: begin
					if (c == CH_CR) begin
						n.parse_state = S_NL3;
					end else if (cur.seen_header && (c == CH_SP || c == CH_TAB)) begin
						n.parse_state = S_LWS;
					end else if (!is_token(c)) begin
						ok = 1'b0;
					end else begin
						kind          = KIND_NAME;
						nbeg          = 1'b1;
						n.parse_state = S_NAME;
					end
				end
				S_LWS: begin
					if (c == CH_CR) begin
						n.parse_state = S_NL2;
					end else if (c == CH_SP || c == CH_TAB) begin
						n.parse_state = S_LWS;
					end else if (is_ctl(c)) begin
						ok = 1'b0;
					end else begin
						kind          = KIND_VALUE;
						n.parse_state = S_VALUE;
					end
				end
				S_NAME: begin
					if (c == CH_COLON) n.parse_state = S_SPACE;
					else if (!is_token(c)) ok = 1'b0;
					else kind = KIND_NAME;
				end
				S_SPACE: begin
					if (c == CH_SP) n.parse_state = S_VALUE;
					else ok = 1'b0;
				end
				S_VALUE: begin
					if (c == CH_CR) begin
						n.parse_state = S_NL2;
						n.seen_header = 1'b1;
						hend          = 1'b1;
					end else if (is_ctl(c)) begin
						ok = 1'b0;
					end else begin
						kind = KIND_VALUE;
					end
				end
				S_NL2: begin
					if (c == CH_LF) n.parse_state = S_LINE;
					else ok = 1'b0;
				end
				S_NL3: begin
					if (c == CH_LF) begin
						n.parse_state = S_DONE;
						verdict       = VERDICT_DONE;
					end else begin
						ok = 1'b0;
					end
				end
				default: begin
					ok = 1'b0;
				end
			endcase
			if (!ok) begin
				n       = cur;
				verdict = VERDICT_REJECT;
				kind    = KIND_NONE;
				nbeg    = 1'b0;
				hend    = 1'b0;
			end
		end
	end

	assign nxt = n;

	assign result.verdict       = verdict;
	assign result.text_kind     = kind;
	assign result.text_byte     = (kind != KIND_NONE) ? c : 8'd0;
	assign result.name_begin    = nbeg;
	assign result.header_end    = hend;
	assign result.version_major = n.major_value;
	assign result.version_minor = n.minor_value;
	assign result.resp_code     = n.code_value;

endmodule

@@ design/http_response_header_parser_unit.sv @@
// ----------------------------------------------------------------------------
// HTTP response header parser unit
// Parses a response status line and header block one byte per beat.
// ----------------------------------------------------------------------------
// Usage:
// Bytes enter on the byte channel (byte_valid, byte_stall, byte_beat). Each
// beat carries either one response byte or a restart request. Every accepted
// beat yields exactly one result beat on the result channel (result_valid,
// result_stall, result_beat) with the verdict, the tagged text byte, the
// header markers and the version and status code parsed so far.
// An accepted beat is held in an input register, evaluated by the step logic
// in the next cycle, and its result enters the result register when the
// result side is not stalling. One beat is accepted every cycle while the
// result side takes its beats; the rate is set by the single parser
// context register, which is updated once per beat.
// When the receiver stalls, the result register holds its beat, the input
// register keeps one more beat, and byte_stall then rises until the result
// register is freed.
// Reset clears both valid bits and returns the parser to expecting the
// letter H with versions, status code and the header flag at zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module http_response_header_parser_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  hrhp_pkg::in_beat_t   byte_beat,
	output logic                 result_valid,
	input  logic                 result_stall,
	output hrhp_pkg::out_beat_t  result_beat
);
	import hrhp_pkg::*;

	logic       valid_s1;
	in_beat_t   beat_s1;
	parse_ctx_t ctx_q;
	parse_ctx_t ctx_nxt;
	out_beat_t  step_result;
	logic       result_valid_q;
	out_beat_t  result_q;
	logic       advance;

	assign advance    = !result_valid_q || !result_stall;
	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			beat_s1 <= byte_beat;
		end
	end

	hrhp_step u_step (
		.beat   (beat_s1),
		.cur    (ctx_q),
		.nxt    (ctx_nxt),
		.result (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.parse_state <= S_H;
			ctx_q.major_value <= 8'd0;
			ctx_q.minor_value <= 8'd0;
			ctx_q.code_value  <= 16'd0;
			ctx_q.seen_header <= 1'b0;
		end else if (valid_s1 && advance) begin
			ctx_q <= ctx_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			result_q <= step_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result_beat  = result_q;

	`include "http_response_header_parser_unit_macros.svh"

	`HRHP_ASSERT_SAME(a_reject_no_text, result_valid_q && result_q.verdict == VERDICT_REJECT, result_q.text_kind == KIND_NONE && !result_q.name_begin && !result_q.header_end)
	`HRHP_ASSERT_SAME(a_header_end_seen, result_valid_q && result_q.header_end, ctx_q.seen_header)
	`HRHP_ASSERT_SAME(a_stall_holds_beat, byte_stall, valid_s1 && result_valid_q)
	`HRHP_ASSERT_SAME(a_state_in_range, 1'b1, ctx_q.parse_state <= S_DONE)
	`HRHP_ASSERT_NEXT(a_step_moves_out, valid_s1 && advance, result_valid_q)

endmodule

@@ tb/http_response_header_parser_unit_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP response header parser checker
// Watches both channels of the parser. It predicts the result of every
// accepted byte beat with its own model of the status-line and header state
// machine, and compares each accepted result beat with the oldest prediction.
// ----------------------------------------------------------------------------

module http_response_header_parser_unit_checker
	import hrhp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	input  logic      byte_stall,
	input  in_beat_t  byte_beat,
	input  logic      result_valid,
	input  logic      result_stall,
	input  out_beat_t result_beat,
	output int        mismatches,
	output int        outstanding
);

	logic [4:0]  parse_st;
	logic [7:0]  major_acc;
	logic [7:0]  minor_acc;
	logic [15:0] code_acc;
	logic        header_seen;
	out_beat_t   predicted_results[$];
	int          fault_total;

	function automatic logic is_control_char(input logic [7:0] c);
		return (c <= CTL_MAX) || (c == CH_DEL);
	endfunction

	function automatic logic is_decimal(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_sep_char(input logic [7:0] c);
		case (c)
			"(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
			"/", "[", "]", "?", "=", "{", "}", " ", "\t": begin
				return 1'b1;
			end
			default: begin
				return 1'b0;
			end
		endcase
	endfunction

	function automatic logic is_name_char(input logic [7:0] c);
		return !c[7] && !is_control_char(c) && !is_sep_char(c);
	endfunction

	function automatic logic [15:0] decimal_push(input logic [15:0] v, input logic [7:0] c,
			input int unsigned cap);
		int unsigned sum;
		sum = 32'(v) * 10 + 32'(c) - 32'(CH_ZERO);
		return (sum > cap) ? 16'(cap) : 16'(sum);
	endfunction

	// Advances the parser state by one beat and returns the result it yields.
	function automatic out_beat_t parse_step(input in_beat_t b);
		out_beat_t  r;
		logic [7:0] c;
		logic [4:0] nxt;
		logic       ok;
		r = '0;
		c = b.data_byte;
		nxt = parse_st;
		ok = 1'b1;
		if (b.req_type == REQ_RESTART) begin
			parse_st = S_H;
		end else begin
			case (parse_st)
				S_H: begin
					if (c == CH_H) nxt = S_T1; else ok = 1'b0;
				end
				S_T1: begin
					if (c == CH_T) nxt = S_T2; else ok = 1'b0;
				end
				S_T2: begin
					if (c == CH_T) nxt = S_P; else ok = 1'b0;
				end
				S_P: begin
					if (c == CH_P) nxt = S_SLASH; else ok = 1'b0;
				end
				S_SLASH: begin
					if (c == CH_SLASH) begin
						major_acc = '0;
						minor_acc = '0;
						code_acc = '0;
						nxt = S_MAJ0;
					end else begin
						ok = 1'b0;
					end
				end
				S_MAJ0: begin
					if (is_decimal(c)) begin
						major_acc = 8'(decimal_push(16'(major_acc), c, 255));
						nxt = S_MAJ;
					end else begin
						ok = 1'b0;
					end
				end
				S_MAJ: begin
					if (c == CH_DOT) nxt = S_MIN0;
					else if (is_decimal(c)) major_acc = 8'(decimal_push(16'(major_acc), c, 255));
					else ok = 1'b0;
				end
				S_MIN0: begin
					if (is_decimal(c)) begin
						minor_acc = 8'(decimal_push(16'(minor_acc), c, 255));
						nxt = S_MIN;
					end else begin
						ok = 1'b0;
					end
				end
				S_MIN: begin
					if (c == CH_SP) nxt = S_CODE0;
					else if (is_decimal(c)) minor_acc = 8'(decimal_push(16'(minor_acc), c, 255));
					else ok = 1'b0;
				end
				S_CODE0: begin
					if (c >= CH_ONE && c <= CH_NINE) begin
						code_acc = decimal_push(code_acc, c, 65535);
						nxt = S_CODE;
					end else begin
						ok = 1'b0;
					end
				end
				S_CODE: begin
					if (c == CH_SP) nxt = S_STEXT;
					else if (is_decimal(c)) code_acc = decimal_push(code_acc, c, 65535);
					else ok = 1'b0;
				end
				S_STEXT: begin
					if (c == CH_CR) nxt = S_NL1;
					else if (is_control_char(c)) ok = 1'b0;
					else r.text_kind = KIND_STATUS;
				end
				S_NL1: begin
					if (c == CH_LF) nxt = S_LINE; else ok = 1'b0;
				end
				S_LINE: begin
					if (c == CH_CR) begin
						nxt = S_NL3;
					end else if (header_seen && (c == CH_SP || c == CH_TAB)) begin
						nxt = S_LWS;
					end else if (!is_name_char(c)) begin
						ok = 1'b0;
					end else begin
						r.text_kind = KIND_NAME;
						r.name_begin = 1'b1;
						nxt = S_NAME;
					end
				end
				S_LWS: begin
					if (c == CH_CR) begin
						nxt = S_NL2;
					end else if (c == CH_SP || c == CH_TAB) begin
						nxt = S_LWS;
					end else if (is_control_char(c)) begin
						ok = 1'b0;
					end else begin
						r.text_kind = KIND_VALUE;
						nxt = S_VALUE;
					end
				end
				S_NAME: begin
					if (c == CH_COLON) nxt = S_SPACE;
					else if (!is_name_char(c)) ok = 1'b0;
					else r.text_kind = KIND_NAME;
				end
				S_SPACE: begin
					if (c == CH_SP) nxt = S_VALUE; else ok = 1'b0;
				end
				S_VALUE: begin
					if (c == CH_CR) begin
						nxt = S_NL2;
						r.header_end = 1'b1;
						header_seen = 1'b1;
					end else if (is_control_char(c)) begin
						ok = 1'b0;
					end else begin
						r.text_kind = KIND_VALUE;
					end
				end
				S_NL2: begin
					if (c == CH_LF) nxt = S_LINE; else ok = 1'b0;
				end
				S_NL3: begin
					if (c == CH_LF) begin
						nxt = S_DONE;
						r.verdict = VERDICT_DONE;
					end else begin
						ok = 1'b0;
					end
				end
				default: begin
					ok = 1'b0;
				end
			endcase
			if (ok) begin
				parse_st = nxt;
			end else begin
				r.verdict = VERDICT_REJECT;
				r.text_kind = KIND_NONE;
				r.name_begin = 1'b0;
				r.header_end = 1'b0;
			end
		end
		r.text_byte = (r.text_kind != KIND_NONE) ? c : 8'h00;
		r.version_major = major_acc;
		r.version_minor = minor_acc;
		r.resp_code = code_acc;
		return r;
	endfunction

	function automatic string show_beat(input out_beat_t b);
		return $sformatf("verdict=%0d kind=%0d byte=%02h begin=%0b end=%0b major=%0d minor=%0d code=%0d",
			b.verdict, b.text_kind, b.text_byte, b.name_begin, b.header_end,
			b.version_major, b.version_minor, b.resp_code);
	endfunction

	task automatic note_fault(input string what);
		if (fault_total < 10) $display("%0t: %s", $realtime, what);
		fault_total++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_beat_t want;
		if (!arst_n) begin
			parse_st = S_H;
			major_acc = '0;
			minor_acc = '0;
			code_acc = '0;
			header_seen = 1'b0;
			predicted_results.delete();
			fault_total = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (predicted_results.size() == 0) begin
					note_fault({"result beat with no prediction waiting: ", show_beat(result_beat)});
				end else begin
					want = predicted_results.pop_front();
					if (result_beat.verdict !== want.verdict ||
							result_beat.text_kind !== want.text_kind ||
							result_beat.text_byte !== want.text_byte ||
							result_beat.name_begin !== want.name_begin ||
							result_beat.header_end !== want.header_end ||
							result_beat.version_major !== want.version_major ||
							result_beat.version_minor !== want.version_minor ||
							result_beat.resp_code !== want.resp_code) begin
						note_fault({"result mismatch: expected ", show_beat(want),
							" got ", show_beat(result_beat)});
					end
				end
			end
			if (byte_valid && !byte_stall) begin
				predicted_results.insert(predicted_results.size(), parse_step(byte_beat));
			end
			mismatches <= fault_total;
			outstanding <= predicted_results.size();
		end
	end

endmodule

@@ tb/http_response_header_parser_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP response header parser testbench
// Feeds the parser a short directed response followed by random responses,
// mostly well formed with random content and some noise, restarts and broken
// lines. Both channels idle at random. The checker beside the parser judges
// every result beat; this module gives the verdict.
// ----------------------------------------------------------------------------

module http_response_header_parser_unit_tb;

	import hrhp_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      byte_valid = 1'b0;
	logic      byte_stall;
	in_beat_t  byte_beat = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_beat_t result_beat;
	int        mismatches;
	int        outstanding;
	logic      no_idle = 1'b0;
	in_beat_t  response_beats[$];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	http_response_header_parser_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_beat    (byte_beat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_beat  (result_beat)
	);

	http_response_header_parser_unit_checker parse_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_beat    (byte_beat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_beat  (result_beat),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	task automatic push_byte(input logic [7:0] c);
		in_beat_t b;
		b.req_type = REQ_BYTE;
		b.data_byte = c;
		response_beats = {response_beats, b};
	endtask

	task automatic push_restart();
		in_beat_t b;
		b.req_type = REQ_RESTART;
		b.data_byte = 8'($urandom_range(255));
		response_beats = {response_beats, b};
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) push_byte(s[i]);
	endtask

	// Occasionally a stray byte or a restart lands in front of the byte,
	// or the byte itself is garbled.
	task automatic jitter_byte(input logic [7:0] c);
		int roll;
		roll = $urandom_range(199);
		if (roll < 2) push_restart();
		else if (roll < 10) push_byte(8'($urandom_range(255)));
		push_byte((roll >= 10 && roll < 14) ? 8'($urandom_range(255)) : c);
	endtask

	function automatic logic [7:0] digit_char();
		return 8'(CH_ZERO + $urandom_range(9));
	endfunction

	function automatic logic [7:0] text_char();
		int roll;
		roll = $urandom_range(99);
		if (roll < 70) return 8'($urandom_range(32, 126));
		if (roll < 85) return 8'($urandom_range(128, 255));
		if (roll < 93) return CH_TAB;
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] name_char();
		string pool;
		int roll;
		pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_";
		roll = $urandom_range(99);
		if (roll < 75) return pool[$urandom_range(pool.len() - 1)];
		if (roll < 92) return 8'($urandom_range(33, 126));
		return 8'($urandom_range(255));
	endfunction

	task automatic make_response();
		string lead;
		int n;
		lead = "HTTP/";
		if ($urandom_range(9) != 0) push_restart();
		for (int i = 0; i < lead.len(); i++) jitter_byte(lead[i]);
		n = ($urandom_range(14) == 0) ? 4 : $urandom_range(1, 3);
		repeat (n) jitter_byte(digit_char());
		jitter_byte(CH_DOT);
		n = ($urandom_range(14) == 0) ? 4 : $urandom_range(1, 3);
		repeat (n) jitter_byte(digit_char());
		jitter_byte(CH_SP);
		jitter_byte(($urandom_range(19) == 0) ? CH_ZERO : 8'(CH_ONE + $urandom_range(8)));
		n = ($urandom_range(9) == 0) ? $urandom_range(4, 6) : 2;
		repeat (n) jitter_byte(digit_char());
		jitter_byte(CH_SP);
		repeat ($urandom_range(8)) jitter_byte(text_char());
		jitter_byte(CH_CR);
		jitter_byte(CH_LF);
		repeat ($urandom_range(4)) begin
			n = $urandom_range(9);
			if (n < 2) begin
				jitter_byte((n == 0) ? CH_SP : CH_TAB);
				repeat ($urandom_range(4)) jitter_byte(text_char());
			end else if (n == 2) begin
				jitter_byte(CH_TAB);
			end else begin
				repeat ($urandom_range(1, 8)) jitter_byte(name_char());
				jitter_byte(CH_COLON);
				jitter_byte(CH_SP);
				repeat ($urandom_range(6)) jitter_byte(text_char());
			end
			jitter_byte(CH_CR);
			jitter_byte(CH_LF);
		end
		if ($urandom_range(14) != 0) begin
			jitter_byte(CH_CR);
			jitter_byte(CH_LF);
		end
		if ($urandom_range(3) == 0) begin
			repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(255)));
		end
	endtask

	always @(posedge clk) result_stall <= !no_idle && ($urandom_range(99) < 13);

	initial begin
		int idx;
		// Saturating versions and code, non-ASCII and control bytes in the
		// status text, a refused continuation before any header, a non-ASCII
		// byte inside a name, a whitespace-only line, and a byte after the end.
		push_restart();
		push_text("HTTP/999.1 99999 ");
		push_byte(8'hFF);
		push_byte(8'h00);
		push_byte(CH_CR);
		push_byte(CH_LF);
		push_byte(CH_SP);
		push_byte("a");
		push_byte(8'h80);
		push_byte(CH_COLON);
		push_byte(CH_SP);
		push_byte(8'hFF);
		push_byte(CH_CR);
		push_byte(CH_LF);
		push_byte(CH_TAB);
		push_byte(CH_CR);
		push_byte(CH_LF);
		push_byte(CH_CR);
		push_byte(CH_LF);
		push_byte(CH_H);
		push_restart();
		while (response_beats.size() < 1420) make_response();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		idx = 0;
		while (idx < response_beats.size()) begin
			@(posedge clk);
			if (byte_valid && !byte_stall) idx++;
			no_idle <= (idx >= 500 && idx < 850);
			if (!byte_valid || !byte_stall) begin
				if (idx < response_beats.size() && (no_idle || $urandom_range(99) >= 13)) begin
					byte_valid <= 1'b1;
					byte_beat <= response_beats[idx];
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
